// File: hdl/rlh_pkg.sv
// ----------------------------------------------------------------------------
// rlh_pkg
// Types and constants shared by the luma/RGB histogram front end, command
// queue and bin memory back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rlh_pkg;

  // Channel bytes and bin fields are one byte wide; the deepest histogram has 256 bins
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned HIST_NUM = 4;
  localparam int unsigned OUT_W    = 32;
  localparam logic [OUT_W-1:0] OUT_MAX = 32'hFFFF_FFFF;

  // Histogram order in the bin store
  localparam logic [SEL_W-1:0] HIST_LUMA  = 2'd0;
  localparam logic [SEL_W-1:0] HIST_BLUE  = 2'd1;
  localparam logic [SEL_W-1:0] HIST_GREEN = 2'd2;
  localparam logic [SEL_W-1:0] HIST_RED   = 2'd3;

  // Luma weights and divide-by-ten as multiply by 6554 / 2^16 (exact for sums up to 2550)
  localparam int unsigned LUMA_SUM_W  = 12;
  localparam int unsigned LUMA_RECIP  = 6554;
  localparam int unsigned LUMA_SHIFT  = 16;
  localparam int unsigned LUMA_PROD_W = 25;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic [CHAN_W-1:0]  luma_bin;
    logic [CHAN_W-1:0]  blue_bin;
    logic [CHAN_W-1:0]  green_bin;
    logic [CHAN_W-1:0]  red_bin;
    logic [SEL_W-1:0]   sel;
    logic [CHAN_W-1:0]  rd_bin;
    logic               rd_oor;
  } hist_cmd_t;

endpackage

`default_nettype wire

// File: hdl/rgb_luma_histogram.sv
// Throughput: the front end accepts one request per cycle until its stage and the
// two-entry command queue fill; the back end takes one command at a time: a pixel is a
// bin memory read, then a write back, and a read is a bin memory read, then a result capture.
// Reset: collection disabled; a clearing pass zeroes every bin while requests wait in
// the queue.
// ----------------------------------------------------------------------------
// rgb_luma_histogram
// Luminance, blue, green and red histograms of a pixel stream with clear,
// accumulate and bin read requests, and a collection enable register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_luma_histogram
  import rlh_pkg::*;
#(
  parameter int unsigned BINS        = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [SEL_W-1:0]  histogram_select_i,
  input  wire logic [CHAN_W-1:0] bin_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [OUT_W-1:0]       bin_count_o
);

  logic       collect_enable_q;
  logic       q_push_valid;
  logic       q_push_ready;
  hist_cmd_t  q_push_cmd;
  logic       q_head_valid;
  hist_cmd_t  q_head_cmd;
  logic       q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collect_enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      collect_enable_q <= cfg_data_i;
    end
  end

  rlh_front #(
    .BINS (BINS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .collect_enable_i   (collect_enable_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .blue_i             (blue_i),
    .green_i            (green_i),
    .red_i              (red_i),
    .histogram_select_i (histogram_select_i),
    .bin_index_i        (bin_index_i),
    .push_valid_o       (q_push_valid),
    .push_ready_i       (q_push_ready),
    .push_cmd_o         (q_push_cmd)
  );

  rlh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_cmd_i   (q_push_cmd),
    .head_valid_o (q_head_valid),
    .head_cmd_o   (q_head_cmd),
    .pop_i        (q_pop)
  );

  rlh_back #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_cmd_i   (q_head_cmd),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_count_o  (bin_count_o)
  );

`ifndef SYNTH
  // A result only ever follows a read command taken from the queue and passed through ST_RESULT
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop && (q_head_cmd.kind == OP_READ), 2))
    else $error("result without a preceding read command");

  // The front end only stalls on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !q_push_ready)
    else $error("input stalled while the queue had room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// File: hdl/rlh_front.sv
// ----------------------------------------------------------------------------
// rlh_front
// Accepts requests, drops those that have no effect, works out the luma value
// and maps every value to its bin before handing a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_front
  import rlh_pkg::*;
#(
  parameter int unsigned BINS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              collect_enable_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [SEL_W-1:0]  histogram_select_i,
  input  wire logic [CHAN_W-1:0] bin_index_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output hist_cmd_t              push_cmd_o
);

  localparam int unsigned BIN_PROD_W = 2 * CHAN_W + 1;

  logic                    stg_valid_q;
  op_e                     stg_op_q;
  logic [CHAN_W-1:0]       stg_luma_q;
  logic [CHAN_W-1:0]       stg_blue_q;
  logic [CHAN_W-1:0]       stg_green_q;
  logic [CHAN_W-1:0]       stg_red_q;
  logic [SEL_W-1:0]        stg_sel_q;
  logic [CHAN_W-1:0]       stg_rd_bin_q;
  logic                    stg_oor_q;

  logic                    accept;
  logic                    useful;
  logic [LUMA_SUM_W-1:0]   luma_sum;
  logic [LUMA_PROD_W-1:0]  luma_prod;

  // Value 0..255 to bin (v * BINS) >> 8
  function automatic logic [CHAN_W-1:0] to_bin(input logic [CHAN_W-1:0] v);
    logic [BIN_PROD_W-1:0] p;
    p = BIN_PROD_W'(v) * BIN_PROD_W'(BINS);
    return p[CHAN_W +: CHAN_W];
  endfunction

  assign in_ready_o = !stg_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    case (operation_i)
      OP_CLEAR, OP_PIXEL: useful = collect_enable_i;
      OP_READ:            useful = 1'b1;
      default:            useful = 1'b0;
    endcase
  end

  assign luma_sum  = LUMA_SUM_W'(blue_i) + LUMA_SUM_W'(green_i) * LUMA_SUM_W'(6)
                   + LUMA_SUM_W'(red_i) * LUMA_SUM_W'(3);
  assign luma_prod = LUMA_PROD_W'(luma_sum) * LUMA_PROD_W'(LUMA_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (accept && useful) begin
      stg_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && useful) begin
      stg_op_q     <= op_e'(operation_i);
      stg_luma_q   <= luma_prod[LUMA_SHIFT +: CHAN_W];
      stg_blue_q   <= blue_i;
      stg_green_q  <= green_i;
      stg_red_q    <= red_i;
      stg_sel_q    <= histogram_select_i;
      stg_rd_bin_q <= bin_index_i;
      stg_oor_q    <= ({1'b0, bin_index_i} >= (CHAN_W + 1)'(BINS));
    end
  end

  assign push_valid_o = stg_valid_q;

  always_comb begin
    push_cmd_o.kind      = stg_op_q;
    push_cmd_o.luma_bin  = to_bin(stg_luma_q);
    push_cmd_o.blue_bin  = to_bin(stg_blue_q);
    push_cmd_o.green_bin = to_bin(stg_green_q);
    push_cmd_o.red_bin   = to_bin(stg_red_q);
    push_cmd_o.sel       = stg_sel_q;
    push_cmd_o.rd_bin    = stg_rd_bin_q;
    push_cmd_o.rd_oor    = stg_oor_q;
  end

endmodule

`default_nettype wire

// File: hdl/rlh_queue.sv
// ----------------------------------------------------------------------------
// rlh_queue
// Short command queue that lets the front end and the bin back end stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_queue
  import rlh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire hist_cmd_t  push_cmd_i,
  output logic            head_valid_o,
  output hist_cmd_t       head_cmd_o,
  input  wire logic       pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  hist_cmd_t         entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rlh_back.sv
// ----------------------------------------------------------------------------
// rlh_back
// Four bin memories, zeroed by a clearing pass after reset and on every clear
// command. Executes pixel read-modify-write and bin read commands, and holds
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlh_back
  import rlh_pkg::*;
#(
  parameter int unsigned BINS        = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire hist_cmd_t        head_cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [OUT_W-1:0]      bin_count_o
);

  localparam int unsigned AW = $clog2(BINS);
  localparam int unsigned XW = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT,
    ST_CLEAR
  } state_e;

  state_e                  state_q;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        out_count_q;
  logic [SEL_W-1:0]        sel_q;
  logic                    oor_q;
  logic [AW-1:0]           upd_addr_q [HIST_NUM];
  logic [AW-1:0]           clr_addr_q;

  logic [CHAN_W-1:0]       head_bin    [HIST_NUM];
  logic [AW-1:0]           rd_addr     [HIST_NUM];
  logic [COUNT_WIDTH-1:0]  rd_data_q   [HIST_NUM];
  logic [COUNT_WIDTH-1:0]  cur         [HIST_NUM];
  logic [COUNT_WIDTH-1:0]  wr_data     [HIST_NUM];
  logic [AW-1:0]           mem_wr_addr [HIST_NUM];
  logic [COUNT_WIDTH-1:0]  mem_wr_data [HIST_NUM];

  logic                    rd_en;
  logic                    wr_en;
  logic [COUNT_WIDTH-1:0]  sel_count;
  logic [XW-1:0]           sel_wide;
  logic [OUT_W-1:0]        result;

  // A read waits until the result register is free, so a capture never collides
  assign pop_o = (state_q == ST_IDLE) && head_valid_i
               && ((head_cmd_i.kind != OP_READ) || !out_valid_q);
  assign rd_en = pop_o && ((head_cmd_i.kind == OP_PIXEL) || (head_cmd_i.kind == OP_READ));
  assign wr_en = (state_q == ST_UPDATE) || (state_q == ST_CLEAR);

  always_comb begin
    head_bin[HIST_LUMA]  = head_cmd_i.luma_bin;
    head_bin[HIST_BLUE]  = head_cmd_i.blue_bin;
    head_bin[HIST_GREEN] = head_cmd_i.green_bin;
    head_bin[HIST_RED]   = head_cmd_i.red_bin;
  end

  for (genvar h = 0; h < HIST_NUM; h++) begin : g_hist
    logic [COUNT_WIDTH-1:0] mem [BINS];

    assign rd_addr[h] = (head_cmd_i.kind == OP_READ) ? head_cmd_i.rd_bin[AW-1:0]
                                                     : head_bin[h][AW-1:0];
    assign cur[h]     = rd_data_q[h];
    assign wr_data[h] = (cur[h] == '1) ? cur[h] : cur[h] + COUNT_WIDTH'(1);

    // Zero one bin per cycle while clearing, else write back the update
    assign mem_wr_addr[h] = (state_q == ST_CLEAR) ? clr_addr_q : upd_addr_q[h];
    assign mem_wr_data[h] = (state_q == ST_CLEAR) ? '0 : wr_data[h];

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[mem_wr_addr[h]] <= mem_wr_data[h];
      end
      if (rd_en) begin
        rd_data_q[h] <= mem[rd_addr[h]];
      end
    end
  end

  assign sel_count = cur[sel_q];
  assign sel_wide  = XW'(sel_count);
  assign result    = oor_q                     ? '0
                   : (sel_wide > XW'(OUT_MAX)) ? OUT_MAX
                   : sel_wide[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      sel_q       <= HIST_LUMA;
      oor_q       <= 1'b0;
      for (int h = 0; h < HIST_NUM; h++) begin
        upd_addr_q[h] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (head_cmd_i.kind)
              OP_PIXEL: begin
                state_q <= ST_UPDATE;
                for (int h = 0; h < HIST_NUM; h++) begin
                  upd_addr_q[h] <= rd_addr[h];
                end
              end
              OP_READ: begin
                state_q <= ST_RESULT;
                sel_q   <= head_cmd_i.sel;
                oor_q   <= head_cmd_i.rd_oor;
              end
              OP_CLEAR: begin
                state_q    <= ST_CLEAR;
                clr_addr_q <= '0;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_UPDATE: state_q <= ST_IDLE;
        ST_RESULT: begin
          out_valid_q <= 1'b1;
          out_count_q <= result;
          state_q     <= ST_IDLE;
        end
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_count_o = out_count_q;

endmodule

`default_nettype wire
